>>> rtl/wtfp_pkg.sv
// Shared types and constants for the write-track format parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wtfp_pkg;

    // Default sizing
    localparam int DEF_BUFFER_BYTES = 16384;
    localparam int DEF_HEADER_BYTES = 8;
    localparam int DEF_FLAG_OFFSET  = 4;
    localparam int DEF_SIZE_OFFSET  = 6;
    localparam int DEF_GAP_LIMIT    = 256;
    localparam int DEF_QUEUE_DEPTH  = 2;

    // Fixed field widths
    localparam int ADDR_W = 14;
    localparam int LEN_W  = 15;
    localparam int BYTE_W = 8;
    localparam int FP_W   = 11;
    localparam int SIZE_W = 11;

    // Format bytes
    localparam logic [7:0] BYTE_GAP   = 8'h4E;
    localparam logic [7:0] BYTE_SYNC  = 8'h00;
    localparam logic [7:0] BYTE_END   = 8'hF4;
    localparam logic [7:0] BYTE_A1    = 8'hF5;
    localparam logic [7:0] BYTE_C2    = 8'hF6;
    localparam logic [7:0] BYTE_IDXAM = 8'hFC;
    localparam logic [7:0] BYTE_IDAM  = 8'hFE;
    localparam logic [7:0] BYTE_DAM   = 8'hFB;
    localparam logic [7:0] BYTE_DDAM  = 8'hF8;
    localparam logic [7:0] BYTE_CRC   = 8'hF7;

    // Input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    typedef enum logic [6:0] {
        M_END  = 7'b0000001,
        M_GAP  = 7'b0000010,
        M_SYNC = 7'b0000100,
        M_IM   = 7'b0001000,
        M_AM   = 7'b0010000,
        M_ID   = 7'b0100000,
        M_DATA = 7'b1000000
    } t_mode;

    // One classified item: either one result, or a pair of byte writes
    // to consecutive addresses (the little-endian size word).
    typedef struct packed {
        logic              pair;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] val;
        logic [BYTE_W-1:0] val_hi;
        logic              done;
        logic              err;
        logic [7:0]        sectors;
        logic [LEN_W-1:0]  img_len;
        logic              active;
    } t_cmd;

endpackage

>>> rtl/wtfp_front.sv
// Front end: accepts input items, runs the format mode machine and
// emits one command per item. Depends on wtfp_pkg.
`timescale 1ns / 1ps

module wtfp_front #(
    parameter int BUFFER_BYTES = wtfp_pkg::DEF_BUFFER_BYTES,
    parameter int HEADER_BYTES = wtfp_pkg::DEF_HEADER_BYTES,
    parameter int FLAG_OFFSET  = wtfp_pkg::DEF_FLAG_OFFSET,
    parameter int SIZE_OFFSET  = wtfp_pkg::DEF_SIZE_OFFSET,
    parameter int GAP_LIMIT    = wtfp_pkg::DEF_GAP_LIMIT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_action,
    input  logic [7:0]      i_data_byte,
    input  logic            i_drive_writable,
    input  logic            i_motor_on,
    input  logic            i_full,
    output logic            o_push,
    output wtfp_pkg::t_cmd  o_cmd
);
    import wtfp_pkg::*;

    localparam int POS_W = $clog2(BUFFER_BYTES + 1);
    localparam int SUM_W = POS_W + 2;

    logic              r_active, n_active;
    t_mode             r_mode, n_mode;
    logic [FP_W-1:0]   r_fp, n_fp;
    logic [POS_W-1:0]  r_img, n_img;
    logic [POS_W-1:0]  r_dpos, n_dpos;
    logic [SIZE_W-1:0] r_dsize, n_dsize;
    logic [7:0]        r_sectors, n_sectors;
    logic [1:0]        r_size_n, n_size_n;

    logic              accept;
    logic [FP_W-1:0]   fp_inc;
    logic [SIZE_W-1:0] sz;
    logic [SUM_W-1:0]  fit_sum;
    logic [POS_W-1:0]  hdr_dpos;
    logic [POS_W:0]    addr_calc;
    logic [31:0]       len_ext;
    logic              we, pair, done, err;
    logic [7:0]        val, val_hi;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    assign fp_inc   = r_fp + FP_W'(1);
    assign sz       = SIZE_W'(128) << r_size_n;
    assign fit_sum  = SUM_W'(r_img) + SUM_W'(2 * HEADER_BYTES) + SUM_W'(sz);
    assign hdr_dpos = r_img + POS_W'(HEADER_BYTES);

    always_comb begin
        n_active  = r_active;
        n_mode    = r_mode;
        n_fp      = r_fp;
        n_img     = r_img;
        n_dpos    = r_dpos;
        n_dsize   = r_dsize;
        n_sectors = r_sectors;
        n_size_n  = r_size_n;
        we        = 1'b0;
        pair      = 1'b0;
        done      = 1'b0;
        err       = 1'b0;
        val       = '0;
        val_hi    = '0;
        addr_calc = '0;

        if (i_action == ACT_START) begin
            n_active = i_drive_writable;
            if (i_drive_writable) begin
                n_img     = '0;
                n_mode    = M_END;
                n_sectors = '0;
                n_fp      = '0;
                n_dpos    = '0;
                n_dsize   = '0;
                n_size_n  = '0;
            end
        end else if (r_active && i_motor_on) begin
            unique case (r_mode)
                M_END: begin
                    if (i_data_byte == BYTE_GAP) begin
                        n_mode = M_GAP;
                        n_fp   = '0;
                    end
                end
                M_GAP: begin
                    if (i_data_byte == BYTE_GAP) begin
                        n_fp = fp_inc;
                        done = ({1'b0, fp_inc} >= (FP_W + 1)'(GAP_LIMIT));
                    end else if (i_data_byte == BYTE_SYNC) begin
                        n_mode = M_SYNC;
                    end else if (i_data_byte == BYTE_END) begin
                        done = 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end
                M_SYNC: begin
                    if (i_data_byte == BYTE_A1) n_mode = M_AM;
                    else if (i_data_byte == BYTE_C2) n_mode = M_IM;
                    else if (i_data_byte != BYTE_SYNC) err = 1'b1;
                end
                M_IM: begin
                    if (i_data_byte == BYTE_IDXAM) n_mode = M_END;
                    else if (i_data_byte != BYTE_C2) err = 1'b1;
                end
                M_AM: begin
                    if (i_data_byte == BYTE_IDAM) begin
                        n_mode = M_ID;
                        n_fp   = '0;
                    end else if (i_data_byte == BYTE_DAM || i_data_byte == BYTE_DDAM) begin
                        n_mode = M_DATA;
                        n_fp   = '0;
                        if (r_dsize != '0) begin
                            // deleted-data flag in the header of the current sector
                            we        = 1'b1;
                            addr_calc = (POS_W + 1)'(r_dpos) - (POS_W + 1)'(HEADER_BYTES)
                                        + (POS_W + 1)'(FLAG_OFFSET);
                            val       = {7'd0, (i_data_byte == BYTE_DDAM)};
                        end
                    end
                end
                M_ID: begin
                    if (r_fp == '0 && i_data_byte == BYTE_IDAM) begin
                        // repeated ID mark, skip
                    end else if (r_fp < FP_W'(4)) begin
                        we        = 1'b1;
                        addr_calc = (POS_W + 1)'(r_img) + (POS_W + 1)'(r_fp);
                        val       = i_data_byte;
                        if (r_fp == FP_W'(3)) begin
                            n_size_n = (i_data_byte > 8'd3) ? 2'd3 : i_data_byte[1:0];
                        end
                        n_fp = fp_inc;
                    end else if (i_data_byte == BYTE_CRC) begin
                        n_mode = M_END;
                        if (fit_sum <= SUM_W'(BUFFER_BYTES)) begin
                            n_dpos    = hdr_dpos;
                            n_dsize   = sz;
                            n_img     = hdr_dpos + POS_W'(sz);
                            n_sectors = r_sectors + 8'd1;
                            we        = 1'b1;
                            pair      = 1'b1;
                            addr_calc = (POS_W + 1)'(r_img) + (POS_W + 1)'(SIZE_OFFSET);
                            val       = sz[7:0];
                            val_hi    = {5'd0, sz[10:8]};
                        end else begin
                            err = 1'b1;
                        end
                    end
                end
                M_DATA: begin
                    if (r_fp == '0 && (i_data_byte == BYTE_DAM || i_data_byte == BYTE_DDAM)) begin
                        // repeated data mark, skip
                    end else if (r_fp < r_dsize) begin
                        we        = 1'b1;
                        addr_calc = (POS_W + 1)'(r_dpos) + (POS_W + 1)'(r_fp);
                        val       = i_data_byte;
                        n_fp      = fp_inc;
                    end else if (i_data_byte == BYTE_CRC) begin
                        n_mode  = M_END;
                        n_dsize = '0;
                    end
                end
                default: n_mode = M_END;
            endcase
            if (done || err) n_active = 1'b0;
        end
    end

    assign len_ext = 32'(n_img);

    always_comb begin
        o_cmd.pair    = pair;
        o_cmd.we      = we;
        o_cmd.addr    = addr_calc[ADDR_W-1:0];
        o_cmd.val     = val;
        o_cmd.val_hi  = val_hi;
        o_cmd.done    = done;
        o_cmd.err     = err;
        o_cmd.sectors = n_sectors;
        o_cmd.img_len = len_ext[LEN_W-1:0];
        o_cmd.active  = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_mode    <= M_END;
            r_fp      <= '0;
            r_img     <= '0;
            r_dpos    <= '0;
            r_dsize   <= '0;
            r_sectors <= '0;
            r_size_n  <= '0;
        end else if (accept) begin
            r_active  <= n_active;
            r_mode    <= n_mode;
            r_fp      <= n_fp;
            r_img     <= n_img;
            r_dpos    <= n_dpos;
            r_dsize   <= n_dsize;
            r_sectors <= n_sectors;
            r_size_n  <= n_size_n;
        end
    end

endmodule

>>> rtl/wtfp_queue.sv
// Short command queue between front and back end.
// Depends on wtfp_pkg for the command type.
`timescale 1ns / 1ps

module wtfp_queue #(
    parameter int DEPTH = wtfp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wtfp_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_empty,
    output wtfp_pkg::t_cmd  o_head,
    input  logic            i_pop
);
    import wtfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            if (do_pop)  r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            if (do_push && !do_pop)      r_cnt <= r_cnt + CNT_W'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

endmodule

>>> rtl/wtfp_back.sv
// Back end: expands queued commands into results and holds them in the
// output register until the sink takes them. Depends on wtfp_pkg.
`timescale 1ns / 1ps

module wtfp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  wtfp_pkg::t_cmd              i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_write_enable,
    output logic [wtfp_pkg::ADDR_W-1:0] o_write_address,
    output logic [7:0]                  o_write_value,
    output logic                        o_track_done,
    output logic                        o_track_error,
    output logic [7:0]                  o_sector_count,
    output logic [wtfp_pkg::LEN_W-1:0]  o_image_length,
    output logic                        o_parser_active,
    output logic                        o_last
);
    import wtfp_pkg::*;

    logic              r_valid;
    logic              r_second;
    logic              r_we, r_done, r_err, r_active, r_last;
    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_val, r_sectors;
    logic [LEN_W-1:0]  r_len;
    logic              load, take;

    assign load  = !r_valid || i_ready;
    assign take  = load && !i_empty;
    // pair commands leave the queue only after their second result
    assign o_pop = take && (!i_head.pair || r_second);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= !i_empty;
            if (take) r_second <= i_head.pair && !r_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_we      <= i_head.we;
            r_addr    <= r_second ? i_head.addr + ADDR_W'(1) : i_head.addr;
            r_val     <= r_second ? i_head.val_hi : i_head.val;
            r_done    <= i_head.done;
            r_err     <= i_head.err;
            r_sectors <= i_head.sectors;
            r_len     <= i_head.img_len;
            r_active  <= i_head.active;
            r_last    <= !i_head.pair || r_second;
        end
    end

    assign o_valid         = r_valid;
    assign o_write_enable  = r_we;
    assign o_write_address = r_addr;
    assign o_write_value   = r_val;
    assign o_track_done    = r_done;
    assign o_track_error   = r_err;
    assign o_sector_count  = r_sectors;
    assign o_image_length  = r_len;
    assign o_parser_active = r_active;
    assign o_last          = r_last;

endmodule

>>> rtl/write_track_format_parser_core.sv
// Write-track format parser, top level: front end, command queue, back end.
// Depends on wtfp_pkg, wtfp_front, wtfp_queue and wtfp_back.
//
// Takes one input item per clock while the queue has room. Each item yields
// one result, except an accepted ID CRC byte, which yields two (the low and
// high size bytes); a two-entry command queue absorbs the extra result, and
// o_ready is low while it is full. An item's first result reaches the
// output through the queue and the back end's output register. All parser
// state sits in the front end and is updated in the cycle of the transfer.
`timescale 1ns / 1ps

module write_track_format_parser_core #(
    parameter int BUFFER_BYTES = wtfp_pkg::DEF_BUFFER_BYTES,
    parameter int HEADER_BYTES = wtfp_pkg::DEF_HEADER_BYTES,
    parameter int FLAG_OFFSET  = wtfp_pkg::DEF_FLAG_OFFSET,
    parameter int SIZE_OFFSET  = wtfp_pkg::DEF_SIZE_OFFSET,
    parameter int GAP_LIMIT    = wtfp_pkg::DEF_GAP_LIMIT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_action,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_drive_writable,
    input  logic                        i_motor_on,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_write_enable,
    output logic [wtfp_pkg::ADDR_W-1:0] o_write_address,
    output logic [7:0]                  o_write_value,
    output logic                        o_track_done,
    output logic                        o_track_error,
    output logic [7:0]                  o_sector_count,
    output logic [wtfp_pkg::LEN_W-1:0]  o_image_length,
    output logic                        o_parser_active,
    output logic                        o_last
);
    import wtfp_pkg::*;

    t_cmd push_cmd, head_cmd;
    logic push, pop, full, empty;

    wtfp_front #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .FLAG_OFFSET  (FLAG_OFFSET),
        .SIZE_OFFSET  (SIZE_OFFSET),
        .GAP_LIMIT    (GAP_LIMIT)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_data_byte      (i_data_byte),
        .i_drive_writable (i_drive_writable),
        .i_motor_on       (i_motor_on),
        .i_full           (full),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    wtfp_queue #(
        .DEPTH (DEF_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_cmd),
        .i_pop   (pop)
    );

    wtfp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_head          (head_cmd),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_write_enable  (o_write_enable),
        .o_write_address (o_write_address),
        .o_write_value   (o_write_value),
        .o_track_done    (o_track_done),
        .o_track_error   (o_track_error),
        .o_sector_count  (o_sector_count),
        .o_image_length  (o_image_length),
        .o_parser_active (o_parser_active),
        .o_last          (o_last)
    );

endmodule

>>> rtl/wtfp_checker.sv
// Port-level checks for the write-track format parser, bound to the top.
// Depends on wtfp_pkg and write_track_format_parser_core.
`timescale 1ns / 1ps

module wtfp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_write_enable,
    input logic [wtfp_pkg::ADDR_W-1:0] o_write_address,
    input logic [7:0]                  o_write_value,
    input logic                        o_track_done,
    input logic                        o_track_error,
    input logic                        o_parser_active,
    input logic                        o_last
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_write_address)
            && $stable(o_write_value) && $stable(o_last))
        else $error("result changed while stalled");

    a_end_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_track_done && o_track_error))
        else $error("done and error on one result");

    a_end_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_track_done || o_track_error) |-> !o_parser_active)
        else $error("parser still active after end of run");

    // only the size word splits into two results; its first half is a write
    a_first_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_write_enable && o_parser_active
            && !o_track_done && !o_track_error)
        else $error("non-final result is not a size byte write");

    a_second_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid && o_last && o_write_enable
            && o_write_address == $past(o_write_address) + 14'd1)
        else $error("size word second byte missing or misplaced");

endmodule

bind write_track_format_parser_core wtfp_checker u_wtfp_checker (.*);

>>> verif/write_track_format_parser_core_tb.sv
// Self-checking testbench for write_track_format_parser_core.
// Depends on wtfp_pkg and the RTL of the block; a scoreboard class predicts
// every buffer write and status result from the host byte stream.
`timescale 1ns / 1ps

module write_track_format_parser_core_tb;
    import wtfp_pkg::*;

    localparam int BUFFER_BYTES = DEF_BUFFER_BYTES;
    localparam int HEADER_BYTES = DEF_HEADER_BYTES;
    localparam int FLAG_OFFSET  = DEF_FLAG_OFFSET;
    localparam int SIZE_OFFSET  = DEF_SIZE_OFFSET;
    localparam int GAP_LIMIT    = DEF_GAP_LIMIT;

    localparam int ITEM_TARGET  = 1450;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        val;
        logic              done;
        logic              err;
        logic [7:0]        sectors;
        logic [LEN_W-1:0]  img_len;
        logic              active;
        logic              last;
    } t_wt_result;

    typedef enum int {
        TRACK_NORMAL,
        TRACK_BAD_END,
        TRACK_GAP_LIMIT,
        TRACK_OVERFLOW,
        TRACK_DISARMED,
        TRACK_NOISE,
        TRACK_KINDS
    } t_track_kind;

    class track_image_scoreboard;
        bit          armed;
        t_mode       mode;
        int unsigned field_ptr;
        int unsigned image_pos;
        int unsigned data_pos;
        int unsigned data_size;
        int unsigned sector_cnt;
        int unsigned size_code;
        t_wt_result  expected_writes[$];
        int          failures;

        function new();
            armed      = 1'b0;
            mode       = M_END;
            field_ptr  = 0;
            image_pos  = 0;
            data_pos   = 0;
            data_size  = 0;
            sector_cnt = 0;
            size_code  = 0;
            failures   = 0;
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        function void push_result(logic we, int unsigned addr, int unsigned val,
                                  logic done, logic err, logic last);
            t_wt_result r;
            r.we      = we;
            r.addr    = addr[ADDR_W-1:0];
            r.val     = val[7:0];
            r.done    = done;
            r.err     = err;
            r.sectors = sector_cnt[7:0];
            r.img_len = image_pos[LEN_W-1:0];
            r.active  = armed;
            r.last    = last;
            expected_writes.push_back(r);
        endfunction

        // Steps the format parser by one host item and queues its results.
        function void accept_host_item(logic act, logic [7:0] d, logic wr, logic mot);
            logic        we;
            logic        done;
            logic        err;
            int unsigned addr;
            int unsigned val;
            int unsigned sz;
            int unsigned hdr;
            we   = 1'b0;
            done = 1'b0;
            err  = 1'b0;
            addr = 0;
            val  = 0;
            if (act == ACT_START) begin
                armed = 1'b0;
                if (wr) begin
                    armed      = 1'b1;
                    image_pos  = 0;
                    mode       = M_END;
                    sector_cnt = 0;
                    field_ptr  = 0;
                    data_pos   = 0;
                    data_size  = 0;
                    size_code  = 0;
                end
                push_result(1'b0, 0, 0, 1'b0, 1'b0, 1'b1);
                return;
            end
            if (!armed || !mot) begin
                push_result(1'b0, 0, 0, 1'b0, 1'b0, 1'b1);
                return;
            end
            case (mode)
                M_END: begin
                    if (d == BYTE_GAP) begin
                        mode      = M_GAP;
                        field_ptr = 0;
                    end
                end
                M_GAP: begin
                    if (d == BYTE_GAP) begin
                        field_ptr = (field_ptr + 1) & 32'h7FF;
                        if (field_ptr >= GAP_LIMIT) done = 1'b1;
                    end else if (d == BYTE_SYNC) begin
                        mode = M_SYNC;
                    end else if (d == BYTE_END) begin
                        done = 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end
                M_SYNC: begin
                    if (d == BYTE_A1) mode = M_AM;
                    else if (d == BYTE_C2) mode = M_IM;
                    else if (d != BYTE_SYNC) err = 1'b1;
                end
                M_IM: begin
                    if (d == BYTE_IDXAM) mode = M_END;
                    else if (d != BYTE_C2) err = 1'b1;
                end
                M_AM: begin
                    if (d == BYTE_IDAM) begin
                        mode      = M_ID;
                        field_ptr = 0;
                    end else if (d == BYTE_DAM || d == BYTE_DDAM) begin
                        mode      = M_DATA;
                        field_ptr = 0;
                        // flag byte only lands when a header was laid down
                        if (data_size != 0) begin
                            we   = 1'b1;
                            addr = data_pos - HEADER_BYTES + FLAG_OFFSET;
                            val  = (d == BYTE_DDAM) ? 1 : 0;
                        end
                    end
                end
                M_ID: begin
                    if (field_ptr == 0 && d == BYTE_IDAM) begin
                    end else if (field_ptr < 4) begin
                        we   = 1'b1;
                        addr = image_pos + field_ptr;
                        val  = d;
                        if (field_ptr == 3) size_code = d;
                        field_ptr++;
                    end else if (d == BYTE_CRC) begin
                        sz   = 128 << ((size_code > 3) ? 3 : size_code);
                        mode = M_END;
                        if (image_pos + 2 * HEADER_BYTES + sz <= BUFFER_BYTES) begin
                            hdr        = image_pos;
                            data_pos   = image_pos + HEADER_BYTES;
                            data_size  = sz;
                            image_pos  = data_pos + sz;
                            sector_cnt = (sector_cnt + 1) & 32'hFF;
                            push_result(1'b1, hdr + SIZE_OFFSET, sz & 32'hFF,
                                        1'b0, 1'b0, 1'b0);
                            push_result(1'b1, hdr + SIZE_OFFSET + 1, (sz >> 8) & 32'hFF,
                                        1'b0, 1'b0, 1'b1);
                            return;
                        end
                        err = 1'b1;
                    end
                end
                M_DATA: begin
                    if (field_ptr == 0 && (d == BYTE_DAM || d == BYTE_DDAM)) begin
                    end else if (field_ptr < data_size) begin
                        we   = 1'b1;
                        addr = data_pos + field_ptr;
                        val  = d;
                        field_ptr++;
                    end else if (d == BYTE_CRC) begin
                        mode      = M_END;
                        data_size = 0;
                    end
                end
                default: mode = M_END;
            endcase
            if (done || err) armed = 1'b0;
            push_result(we, addr, val, done, err, 1'b1);
        endfunction

        function string fmt(t_wt_result r);
            return {$sformatf("we=%0b addr=%04h val=%02h done=%0b err=%0b ",
                              r.we, r.addr, r.val, r.done, r.err),
                    $sformatf("sec=%0d len=%0d act=%0b last=%0b",
                              r.sectors, r.img_len, r.active, r.last)};
        endfunction

        function void check_buffer_write(t_wt_result got);
            t_wt_result exp;
            if (expected_writes.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: %s", fmt(got));
                return;
            end
            exp = expected_writes.pop_front();
            if (got !== exp) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected %s", fmt(exp));
                    $display("  actual   %s", fmt(got));
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_action;
    logic [7:0]        i_data_byte;
    logic              i_drive_writable;
    logic              i_motor_on;
    logic              o_valid;
    logic              i_ready;
    logic              o_write_enable;
    logic [ADDR_W-1:0] o_write_address;
    logic [7:0]        o_write_value;
    logic              o_track_done;
    logic              o_track_error;
    logic [7:0]        o_sector_count;
    logic [LEN_W-1:0]  o_image_length;
    logic              o_parser_active;
    logic              o_last;

    track_image_scoreboard sb;
    int items_sent   = 0;
    int stall_cycles = 0;
    int ready_hold   = 0;
    bit sender_burst = 1'b0;
    bit sink_burst   = 1'b0;

    write_track_format_parser_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_data_byte      (i_data_byte),
        .i_drive_writable (i_drive_writable),
        .i_motor_on       (i_motor_on),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_write_enable   (o_write_enable),
        .o_write_address  (o_write_address),
        .o_write_value    (o_write_value),
        .o_track_done     (o_track_done),
        .o_track_error    (o_track_error),
        .o_sector_count   (o_sector_count),
        .o_image_length   (o_image_length),
        .o_parser_active  (o_parser_active),
        .o_last           (o_last)
    );

    always #5 i_clk = ~i_clk;

    // mostly zero, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            i_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            i_ready <= 1'b1;
            if (!sink_burst) ready_hold <= idle_len();
        end
        if ($urandom_range(0, 199) == 0) sink_burst <= !sink_burst;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready)
            sb.check_buffer_write({o_write_enable, o_write_address, o_write_value,
                                   o_track_done, o_track_error, o_sector_count,
                                   o_image_length, o_parser_active, o_last});
    end

    // watchdog: cycles without any transfer on either channel
    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // called at a falling edge; returns at a falling edge
    task automatic send_item(input logic act, input logic [7:0] d, input logic wr,
                             input logic mot);
        int gap;
        i_valid          <= 1'b1;
        i_action         <= act;
        i_data_byte      <= d;
        i_drive_writable <= wr;
        i_motor_on       <= mot;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        sb.accept_host_item(act, d, wr, mot);
        if (act == ACT_START || mot) items_sent++;
        @(negedge i_clk);
        gap = sender_burst ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        if ($urandom_range(0, 99) == 0) sender_burst = !sender_burst;
    endtask

    // host byte with occasional motor-off noise and rare corruption
    task automatic send_byte(input logic [7:0] d);
        if ($urandom_range(0, 99) < 3)
            send_item(ACT_DATA, 8'($urandom), 1'($urandom), 1'b0);
        if ($urandom_range(0, 999) < 5) d = 8'($urandom);
        send_item(ACT_DATA, d, 1'($urandom), 1'b1);
    endtask

    task automatic send_run(input logic [7:0] b, input int n);
        repeat (n) send_byte(b);
    endtask

    task automatic start_track(input logic wr);
        send_item(ACT_START, 8'($urandom), wr, 1'($urandom));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 8'd0;
        if (r < 82) return 8'd1;
        if (r < 90) return 8'd2;
        return 8'($urandom_range(3, 255));
    endfunction

    function automatic logic [7:0] pick_format_byte();
        case ($urandom_range(0, 9))
            0: return BYTE_GAP;
            1: return BYTE_SYNC;
            2: return BYTE_A1;
            3: return BYTE_C2;
            4: return BYTE_IDXAM;
            5: return BYTE_IDAM;
            6: return BYTE_DAM;
            7: return BYTE_DDAM;
            8: return BYTE_CRC;
            default: return BYTE_END;
        endcase
    endfunction

    task automatic send_extras();
        logic [7:0] b;
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 2)) begin
                do b = 8'($urandom); while (b == BYTE_CRC);
                send_byte(b);
            end
        end
    endtask

    task automatic send_sector(input logic [7:0] size_byte, input bit with_data);
        logic [7:0] b;
        int         len;
        send_run(BYTE_GAP, $urandom_range(1, 6));
        send_run(BYTE_SYNC, $urandom_range(1, 4));
        send_run(BYTE_A1, $urandom_range(1, 3));
        send_run(BYTE_IDAM, $urandom_range(1, 2));
        do b = 8'($urandom); while (b == BYTE_IDAM);
        send_byte(b);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_byte(size_byte);
        send_extras();
        send_byte(BYTE_CRC);
        if (with_data) begin
            len = 128 << ((size_byte > 3) ? 3 : size_byte);
            send_run(BYTE_GAP, $urandom_range(1, 6));
            send_run(BYTE_SYNC, $urandom_range(1, 4));
            send_run(BYTE_A1, $urandom_range(1, 3));
            send_run($urandom_range(0, 3) == 0 ? BYTE_DDAM : BYTE_DAM, $urandom_range(1, 2));
            do b = 8'($urandom); while (b == BYTE_DAM || b == BYTE_DDAM);
            send_byte(b);
            repeat (len - 1) send_byte(8'($urandom));
            send_extras();
            send_byte(BYTE_CRC);
        end
    endtask

    task automatic run_track(input t_track_kind kind);
        logic [7:0] b;
        logic [7:0] sz;
        case (kind) inside
            TRACK_NORMAL, TRACK_BAD_END: begin
                start_track(1'b1);
                if ($urandom_range(0, 1)) begin
                    send_run(BYTE_GAP, $urandom_range(1, 6));
                    send_run(BYTE_SYNC, $urandom_range(1, 4));
                    send_run(BYTE_C2, $urandom_range(1, 3));
                    send_byte(BYTE_IDXAM);
                end
                repeat ($urandom_range(1, 3)) begin
                    sz = pick_size();
                    send_sector(sz, (sz <= 1) ? ($urandom_range(0, 99) < 85)
                                              : ($urandom_range(0, 99) < 12));
                end
                send_run(BYTE_GAP, $urandom_range(1, 8));
                if (kind == TRACK_NORMAL) begin
                    send_byte(BYTE_END);
                end else begin
                    do b = 8'($urandom);
                    while (b == BYTE_GAP || b == BYTE_SYNC || b == BYTE_END);
                    send_byte(b);
                end
            end
            TRACK_GAP_LIMIT: begin
                start_track(1'b1);
                if ($urandom_range(0, 1)) send_sector(pick_size(), 1'b0);
                send_run(BYTE_GAP, GAP_LIMIT + 1);
            end
            TRACK_OVERFLOW: begin
                // ID-only sectors of the largest size until the image overflows
                start_track(1'b1);
                repeat (16) send_sector(8'($urandom_range(3, 255)), 1'b0);
            end
            TRACK_DISARMED: begin
                start_track(1'b0);
                repeat (4) send_byte(pick_format_byte());
            end
            default: begin
                start_track(1'b1);
                repeat (24) send_byte(($urandom_range(0, 99) < 40) ? pick_format_byte()
                                                                    : 8'($urandom));
            end
        endcase
    endtask

    task automatic run_directed();
        logic [23:0][7:0] script;
        script = {BYTE_GAP, BYTE_SYNC, BYTE_C2, BYTE_C2, BYTE_IDXAM,
                  BYTE_GAP, BYTE_SYNC, BYTE_A1, BYTE_A1, BYTE_DAM, BYTE_CRC,
                  BYTE_GAP, BYTE_SYNC, BYTE_A1, BYTE_IDAM, BYTE_IDAM,
                  8'hFF, 8'h00, 8'hA5, 8'h07, 8'h33, BYTE_CRC,
                  BYTE_GAP, BYTE_END};
        send_item(ACT_START, 8'h00, 1'b0, 1'b1);   // unwritable drive
        send_item(ACT_DATA, BYTE_GAP, 1'b1, 1'b1); // byte while idle
        send_item(ACT_START, 8'hFF, 1'b1, 1'b0);
        send_item(ACT_DATA, BYTE_GAP, 1'b0, 1'b0); // motor off
        // index mark, data mark with no ID, ID with repeated marks,
        // clamped size code and a trailing extra byte, then F4 end
        for (int k = 23; k >= 0; k--)
            send_item(ACT_DATA, script[k], 1'($urandom), 1'b1);
    endtask

    initial begin
        t_track_kind kind;
        int          track_idx;
        int          r;
        sb               = new();
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_action         = ACT_START;
        i_data_byte      = 8'h00;
        i_drive_writable = 1'b0;
        i_motor_on       = 1'b0;
        i_ready          = 1'b0;
        track_idx        = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            if (track_idx < TRACK_KINDS) begin
                kind = t_track_kind'(track_idx);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) kind = TRACK_NORMAL;
                else if (r < 70) kind = TRACK_BAD_END;
                else if (r < 78) kind = TRACK_GAP_LIMIT;
                else if (r < 85) kind = TRACK_OVERFLOW;
                else if (r < 90) kind = TRACK_DISARMED;
                else kind = TRACK_NOISE;
            end
            run_track(kind);
            track_idx++;
            if ($urandom_range(0, 4) == 0) wait_drained();
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
